// ----- rtl/assert_macros.svh -----
// Assertion macros used by cpu8_alu_flag_unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that cond implies next-cycle consequence.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
// Assert that cond implies consequence in the same cycle.
`define ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
`endif

// ----- rtl/z80alu_pkg.sv -----
// Types and constants of the 8-bit ALU with Z80 flags.
// No dependencies.
package z80alu_pkg;
  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADC = 6'd1, OP_SUB = 6'd2, OP_SBC = 6'd3,
    OP_AND = 6'd4, OP_XOR = 6'd5, OP_OR = 6'd6, OP_CP = 6'd7,
    OP_INC = 6'd8, OP_DEC = 6'd9,
    OP_RLC = 6'd10, OP_RRC = 6'd11, OP_RL = 6'd12, OP_RR = 6'd13,
    OP_SLA = 6'd14, OP_SRA = 6'd15, OP_SLL = 6'd16, OP_SRL = 6'd17,
    OP_BIT = 6'd18, OP_RES = 6'd19, OP_SET = 6'd20,
    OP_RLCA = 6'd21, OP_RLA = 6'd22, OP_RRCA = 6'd23, OP_RRA = 6'd24,
    OP_DAA = 6'd25, OP_CPL = 6'd26, OP_SCF = 6'd27, OP_CCF = 6'd28,
    OP_NEG = 6'd29, OP_ADD16 = 6'd30, OP_ADC16 = 6'd31, OP_SBC16 = 6'd32,
    OP_RRD = 6'd33, OP_RLD = 6'd34
  } op_t;

  localparam int FC = 0;
  localparam int FN = 1;
  localparam int FV = 2;
  localparam int FH = 4;
  localparam int FZ = 6;
  localparam int FS = 7;

  // Decoded item after the first stage.
  typedef struct packed {
    logic [5:0]  op;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [2:0]  bi;
    logic [7:0]  f;
  } item_t;

  // Raw sums after the second stage.
  typedef struct packed {
    logic [5:0]  op;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [7:0]  f;
    logic [16:0] sum;   // main sum (8 or 16 bits plus carry)
    logic [4:0]  hsum;  // low nibble sum for 8-bit
    logic [12:0] hsum16;
    logic [15:0] pre;   // result for non-adder ops
    logic [7:0]  pre_f;
    logic [7:0]  aux;
  } mid_t;

  typedef struct packed {
    logic [15:0] res;
    logic [7:0]  aux;
    logic [7:0]  f;
  } out_t;

  function automatic logic [7:0] szp(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    r[FZ] = (v == 8'h00);
    r[FS] = v[7];
    r[FV] = ~(^v);
    return r;
  endfunction
endpackage

// ----- rtl/z80alu_stage_add.sv -----
// Stage two: adders and non-arithmetic results, registered.
// Depends on z80alu_pkg.
module z80alu_stage_add import z80alu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vin,
  input  item_t din,
  output logic  vout,
  output mid_t  dout
);
  mid_t m;
  logic [7:0] a, b, bx, msk, v;
  logic c, cin;
  logic [7:0] keep;
  logic [7:0] corr;
  logic dc;

  always_comb begin
    a = din.wa[7:0];
    b = din.wb[7:0];
    c = din.f[FC];
    msk = 8'h01 << din.bi;
    m = '0;
    m.op = din.op;
    m.wa = din.wa;
    m.wb = din.wb;
    m.f = din.f;
    m.pre = din.wa;
    m.pre_f = din.f;
    bx = b;
    cin = 1'b0;
    v = 8'h00;
    keep = din.f & ~8'h13;
    corr = 8'h00;
    dc = 1'b0;
    case (din.op)
      OP_ADC: cin = c;
      OP_SUB, OP_CP: begin bx = ~b; cin = 1'b1; end
      OP_SBC: begin bx = ~b; cin = ~c; end
      OP_INC: begin bx = 8'h01; end
      OP_DEC: begin bx = 8'hFF; end
      OP_NEG: begin bx = ~a; cin = 1'b1; end
      default: ;
    endcase
    if (din.op == OP_INC || din.op == OP_DEC) begin
      m.hsum = {1'b0, b[3:0]} + {1'b0, bx[3:0]};
      m.sum = {9'd0, b} + {9'd0, bx};
    end else if (din.op == OP_NEG) begin
      m.hsum = {1'b0, bx[3:0]} + 5'd1;
      m.sum = {9'd0, bx} + 17'd1;
    end else if (din.op == OP_DAA) begin
      // correction applied here, flags in next stage
      dc = (a > 8'h99) || c;
      corr = {1'b0, dc, dc, 5'd0};
      if (a[3:0] > 4'd9 || din.f[FH]) corr = corr | 8'h06;
      m.sum = din.f[FN] ? {9'd0, a - corr} : {9'd0, a + corr};
      m.hsum = {4'd0, dc};
    end else if (din.op == OP_ADD16 || din.op == OP_ADC16 || din.op == OP_SBC16) begin
      bx = 8'h00;
      m.sum = {1'b0, din.wa}
            + (din.op == OP_SBC16 ? {1'b0, ~din.wb} : {1'b0, din.wb})
            + {16'd0, (din.op == OP_ADD16) ? 1'b0 : (din.op == OP_SBC16 ? ~c : c)};
      m.hsum16 = {1'b0, din.wa[11:0]}
            + (din.op == OP_SBC16 ? {1'b0, ~din.wb[11:0]} : {1'b0, din.wb[11:0]})
            + {12'd0, (din.op == OP_ADD16) ? 1'b0 : (din.op == OP_SBC16 ? ~c : c)};
    end else begin
      m.hsum = {1'b0, a[3:0]} + {1'b0, bx[3:0]} + {4'd0, cin};
      m.sum = {9'd0, a} + {9'd0, bx} + {16'd0, cin};
    end

    unique case (din.op)
      OP_AND: m.pre = {8'd0, a & b};
      OP_XOR: m.pre = {8'd0, a ^ b};
      OP_OR:  m.pre = {8'd0, a | b};
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL: begin
        case (din.op)
          OP_RLC: begin v = {b[6:0], b[7]}; m.pre_f = {7'd0, b[7]}; end
          OP_RRC: begin v = {b[0], b[7:1]}; m.pre_f = {7'd0, b[0]}; end
          OP_RL:  begin v = {b[6:0], c}; m.pre_f = {7'd0, b[7]}; end
          OP_RR:  begin v = {c, b[7:1]}; m.pre_f = {7'd0, b[0]}; end
          OP_SLA: begin v = {b[6:0], 1'b0}; m.pre_f = {7'd0, b[7]}; end
          OP_SRA: begin v = {b[7], b[7:1]}; m.pre_f = {7'd0, b[0]}; end
          OP_SLL: begin v = {b[6:0], 1'b1}; m.pre_f = {7'd0, b[7]}; end
          default: begin v = {1'b0, b[7:1]}; m.pre_f = {7'd0, b[0]}; end
        endcase
        m.pre = {8'd0, v};
      end
      OP_BIT: begin
        m.pre = {8'd0, b};
        m.pre_f = (din.f & ~8'h42) | 8'h10;
        m.pre_f[FZ] = ~(|(b & msk));
      end
      OP_RES: m.pre = {8'd0, b & ~msk};
      OP_SET: m.pre = {8'd0, b | msk};
      OP_RLCA: begin m.pre = {8'd0, a[6:0], a[7]}; m.pre_f = keep | {7'd0, a[7]}; end
      OP_RLA:  begin m.pre = {8'd0, a[6:0], c}; m.pre_f = keep | {7'd0, a[7]}; end
      OP_RRCA: begin m.pre = {8'd0, a[0], a[7:1]}; m.pre_f = keep | {7'd0, a[0]}; end
      OP_RRA:  begin m.pre = {8'd0, c, a[7:1]}; m.pre_f = keep | {7'd0, a[0]}; end
      OP_CPL: begin m.pre = {8'd0, ~a}; m.pre_f = din.f | 8'h12; end
      OP_SCF: begin m.pre = {8'd0, a}; m.pre_f = (din.f & ~8'h12) | 8'h01; end
      OP_CCF: begin
        m.pre = {8'd0, a};
        m.pre_f = ((din.f & ~8'h12) ^ 8'h01) | {3'd0, c, 4'd0};
      end
      OP_RRD: begin
        m.aux = {a[3:0], b[7:4]};
        m.pre = {8'd0, a[7:4], b[3:0]};
      end
      OP_RLD: begin
        m.aux = {b[3:0], a[3:0]};
        m.pre = {8'd0, a[7:4], b[7:4]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= m;
    end
  end
endmodule

// ----- rtl/z80alu_stage_flag.sv -----
// Stage three: flag formation and result selection, registered.
// Depends on z80alu_pkg.
module z80alu_stage_flag import z80alu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  mid_t din,
  output logic vout,
  output out_t dout
);
  out_t o;
  logic [7:0] a, b, v, f, nf;

  always_comb begin
    a = din.wa[7:0];
    b = din.wb[7:0];
    f = din.f;
    v = din.sum[7:0];
    nf = 8'h00;
    o.res = din.pre;
    o.aux = din.aux;
    o.f = din.pre_f;
    case (din.op)
      OP_ADD, OP_ADC: begin
        nf[FZ] = (v == 8'h00); nf[FS] = v[7];
        nf[FC] = din.sum[8]; nf[FH] = din.hsum[4];
        nf[FV] = ~(a[7] ^ b[7]) & (a[7] ^ v[7]);
        o.res = {8'd0, v}; o.f = nf;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        nf[FZ] = (v == 8'h00); nf[FS] = v[7]; nf[FN] = 1'b1;
        nf[FC] = ~din.sum[8]; nf[FH] = ~din.hsum[4];
        nf[FV] = (a[7] ^ b[7]) & (a[7] ^ v[7]);
        o.res = (din.op == OP_CP) ? {8'd0, a} : {8'd0, v};
        o.f = nf;
      end
      OP_AND, OP_XOR, OP_OR: begin
        nf = szp(din.pre[7:0]);
        nf[FH] = (din.op == OP_AND);
      end
      OP_INC: begin
        nf[FC] = f[FC]; nf[FZ] = (v == 8'h00); nf[FS] = v[7];
        nf[FV] = (v == 8'h80); nf[FH] = (v[3:0] == 4'h0);
        o.res = {8'd0, v};
      end
      OP_DEC: begin
        nf[FC] = f[FC]; nf[FN] = 1'b1; nf[FZ] = (v == 8'h00); nf[FS] = v[7];
        nf[FV] = (v == 8'h7F); nf[FH] = (v[3:0] == 4'hF);
        o.res = {8'd0, v};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL,
      OP_RRD, OP_RLD: begin
        nf = szp(din.pre[7:0]);
        nf[FC] = (din.op == OP_RRD || din.op == OP_RLD) ? f[FC] : din.pre_f[FC];
      end
      OP_DAA: begin
        nf = (f & ~8'hD5) | szp(v);
        nf[FC] = din.hsum[0];
        nf[FH] = v[4] ^ a[4];
        o.res = {8'd0, v};
      end
      OP_NEG: begin
        nf[FN] = 1'b1; nf[FZ] = (v == 8'h00); nf[FC] = (v != 8'h00);
        nf[FS] = v[7]; nf[FV] = (v == 8'h80); nf[FH] = (v[3:0] != 4'h0);
        o.res = {8'd0, v};
      end
      OP_ADD16: begin
        nf = f & ~8'h13;
        nf[FC] = din.sum[16]; nf[FH] = din.hsum16[12];
        o.res = din.sum[15:0];
      end
      OP_ADC16, OP_SBC16: begin
        nf[FZ] = (din.sum[15:0] == 16'd0); nf[FS] = din.sum[15];
        if (din.op == OP_ADC16) begin
          nf[FC] = din.sum[16]; nf[FH] = din.hsum16[12];
          nf[FV] = ~(din.wa[15] ^ din.wb[15]) & (din.wa[15] ^ din.sum[15]);
        end else begin
          nf[FN] = 1'b1; nf[FC] = ~din.sum[16]; nf[FH] = ~din.hsum16[12];
          nf[FV] = (din.wa[15] ^ din.wb[15]) & (din.wa[15] ^ din.sum[15]);
        end
        o.res = din.sum[15:0];
      end
      default: ;
    endcase
    if (din.op == OP_AND || din.op == OP_XOR || din.op == OP_OR
        || din.op == OP_INC || din.op == OP_DEC || din.op == OP_DAA
        || din.op == OP_NEG || din.op == OP_ADD16 || din.op == OP_ADC16
        || din.op == OP_SBC16 || din.op == OP_RRD || din.op == OP_RLD
        || (din.op >= OP_RLC && din.op <= OP_SRL)) begin
      o.f = nf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= o;
    end
  end
endmodule

// ----- rtl/cpu8_alu_flag_unit.sv -----
// Pipeline: input, adder and flag stages, each registered, from accepted item to result valid.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset: synchronous rst clears all stage valid bits; payload is not reset.
// Depends on z80alu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cpu8_alu_flag_unit import z80alu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  opcode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_index,
  input  logic [7:0]  flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result,
  output logic [7:0]  aux_result,
  output logic [7:0]  flags_out
);
  logic  en;
  logic  v1, v2, v3;
  item_t s1;
  mid_t  s2;
  out_t  s3;

  // Advance everything together when the output slot frees.
  assign en = ~v3 | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= '{op: opcode, wa: operand_a, wb: operand_b, bi: bit_index, f: flags_in};
    end
  end

  z80alu_stage_add u_add (
    .clk(clk), .rst(rst), .en(en), .vin(v1), .din(s1), .vout(v2), .dout(s2)
  );

  z80alu_stage_flag u_flag (
    .clk(clk), .rst(rst), .en(en), .vin(v2), .din(s2), .vout(v3), .dout(s3)
  );

  assign out_valid  = v3;
  assign result     = s3.res;
  assign aux_result = s3.aux;
  assign flags_out  = s3.f;

  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result item dropped")
  `ASSERT_NOW(a_ready, clk, rst, !out_valid, in_ready, "stall without pending result")
  `ASSERT_NEXT(a_move, clk, rst, in_valid && in_ready, v1, "accepted item lost")
endmodule

// ----- dv/cpu8_alu_flag_unit_test.sv -----
// Self-checking testbench for cpu8_alu_flag_unit, the 8-bit ALU with Z80 flags.
// Depends on z80alu_pkg and the RTL; predicts each result and checks it in order.
`timescale 1ns / 100ps
module cpu8_alu_flag_unit_test;
  import z80alu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] res;
    logic [7:0]  aux;
    logic [7:0]  f;
  } alu_out_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  opcode;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [2:0]  bit_index;
  logic [7:0]  flags_in;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] result;
  logic [7:0]  aux_result;
  logic [7:0]  flags_out;

  alu_out_t alu_expected_q[$];
  int       mismatch_cnt;
  int       sent_cnt;
  int       checked_cnt;
  int       idle_cnt;
  bit       timed_out;

  cpu8_alu_flag_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .bit_index(bit_index), .flags_in(flags_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .result(result), .aux_result(aux_result), .flags_out(flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] zsp_flags(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    r[FZ] = (v == 8'h00);
    r[FS] = v[7];
    r[FV] = ~(^v);
    return r;
  endfunction

  function automatic alu_out_t alu_predict(input logic [5:0] op, input logic [15:0] wa,
                                           input logic [15:0] wb, input logic [2:0] bi,
                                           input logic [7:0] f);
    alu_out_t o;
    logic [7:0]  a, b, v8, keep, corr;
    logic [8:0]  s9;
    logic [4:0]  h5;
    logic [16:0] s17;
    logic [12:0] h13;
    logic        cy;
    a = wa[7:0];
    b = wb[7:0];
    cy = f[FC];
    o.res = wa;
    o.aux = 8'h00;
    o.f = f;
    s9 = 9'h0;
    h5 = 5'h0;
    case (op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP, OP_AND, OP_XOR, OP_OR: begin
        case (op)
          OP_ADC: begin
            h5 = a[3:0] + b[3:0] + cy; s9 = a + b + cy;
          end
          OP_SUB, OP_CP: begin
            h5 = {1'b0, a[3:0]} + {1'b0, ~b[3:0]} + 5'd1;
            s9 = {1'b0, a} + {1'b0, ~b} + 9'd1;
          end
          OP_SBC: begin
            h5 = {1'b0, a[3:0]} + {1'b0, ~b[3:0]} + {4'd0, !cy};
            s9 = {1'b0, a} + {1'b0, ~b} + {8'd0, !cy};
          end
          OP_AND: s9 = {1'b0, a & b};
          OP_XOR: s9 = {1'b0, a ^ b};
          OP_OR:  s9 = {1'b0, a | b};
          default: begin
            h5 = a[3:0] + b[3:0]; s9 = a + b;
          end
        endcase
        o.f = 8'h00;
        o.f[FZ] = (s9[7:0] == 8'h00);
        o.f[FS] = s9[7];
        if (op == OP_ADD || op == OP_ADC) begin
          o.f[FC] = s9[8];
          o.f[FH] = h5[4];
          o.f[FV] = ~(a[7] ^ b[7]) & (a[7] ^ s9[7]);
        end else if (op == OP_SUB || op == OP_SBC || op == OP_CP) begin
          o.f[FN] = 1'b1;
          o.f[FC] = !s9[8];
          o.f[FH] = !h5[4];
          o.f[FV] = (a[7] ^ b[7]) & (a[7] ^ s9[7]);
        end else begin
          o.f[FV] = ~(^s9[7:0]);
          o.f[FH] = (op == OP_AND);
        end
        o.res = (op == OP_CP) ? {8'h00, a} : {8'h00, s9[7:0]};
      end
      OP_INC, OP_DEC: begin
        v8 = (op == OP_INC) ? b + 8'd1 : b - 8'd1;
        o.f = 8'h00;
        o.f[FC] = cy;
        o.f[FN] = (op == OP_DEC);
        o.f[FZ] = (v8 == 8'h00);
        o.f[FS] = v8[7];
        o.f[FV] = (op == OP_INC) ? (v8 == 8'h80) : (v8 == 8'h7f);
        o.f[FH] = (op == OP_INC) ? (v8[3:0] == 4'h0) : (v8[3:0] == 4'hf);
        o.res = {8'h00, v8};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL: begin
        case (op)
          OP_RLC: v8 = {b[6:0], b[7]};
          OP_RRC: v8 = {b[0], b[7:1]};
          OP_RL:  v8 = {b[6:0], cy};
          OP_RR:  v8 = {cy, b[7:1]};
          OP_SLA: v8 = {b[6:0], 1'b0};
          OP_SRA: v8 = {b[7], b[7:1]};
          OP_SLL: v8 = {b[6:0], 1'b1};
          default: v8 = {1'b0, b[7:1]};
        endcase
        o.f = zsp_flags(v8);
        o.f[FC] = (op == OP_RLC || op == OP_RL || op == OP_SLA || op == OP_SLL) ? b[7] : b[0];
        o.res = {8'h00, v8};
      end
      OP_BIT: begin
        o.f = f;
        o.f[FN] = 1'b0;
        o.f[FH] = 1'b1;
        o.f[FZ] = !b[bi];
        o.res = {8'h00, b};
      end
      OP_RES: begin
        v8 = b; v8[bi] = 1'b0; o.res = {8'h00, v8};
      end
      OP_SET: begin
        v8 = b; v8[bi] = 1'b1; o.res = {8'h00, v8};
      end
      OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
        keep = f;
        keep[FC] = 1'b0; keep[FN] = 1'b0; keep[FH] = 1'b0;
        case (op)
          OP_RLCA: v8 = {a[6:0], a[7]};
          OP_RLA:  v8 = {a[6:0], cy};
          OP_RRCA: v8 = {a[0], a[7:1]};
          default: v8 = {cy, a[7:1]};
        endcase
        o.f = keep;
        o.f[FC] = (op == OP_RLCA || op == OP_RLA) ? a[7] : a[0];
        o.res = {8'h00, v8};
      end
      OP_DAA: begin
        o.f = f;
        if (a > 8'h99 || f[FC]) begin
          o.f[FC] = 1'b1; corr = 8'h60;
        end else begin
          o.f[FC] = 1'b0; corr = 8'h00;
        end
        if (a[3:0] > 4'd9 || f[FH]) corr[2:1] = 2'b11;
        v8 = f[FN] ? a - corr : a + corr;
        o.f[FV] = 1'b0; o.f[FS] = 1'b0; o.f[FZ] = 1'b0;
        o.f[FH] = v8[4] ^ a[4];
        o.f = o.f | zsp_flags(v8);
        o.res = {8'h00, v8};
      end
      OP_CPL: begin
        o.f[FN] = 1'b1; o.f[FH] = 1'b1;
        o.res = {8'h00, ~a};
      end
      OP_SCF: begin
        o.f[FN] = 1'b0; o.f[FH] = 1'b0; o.f[FC] = 1'b1;
        o.res = {8'h00, a};
      end
      OP_CCF: begin
        o.f[FN] = 1'b0; o.f[FH] = cy; o.f[FC] = !cy;
        o.res = {8'h00, a};
      end
      OP_NEG: begin
        v8 = 8'h00 - a;
        o.f = 8'h00;
        o.f[FN] = 1'b1;
        o.f[FZ] = (v8 == 8'h00);
        o.f[FC] = (v8 != 8'h00);
        o.f[FS] = v8[7];
        o.f[FV] = (v8 == 8'h80);
        o.f[FH] = (v8[3:0] != 4'h0);
        o.res = {8'h00, v8};
      end
      OP_ADD16: begin
        s17 = wa + wb;
        h13 = wa[11:0] + wb[11:0];
        o.f[FN] = 1'b0;
        o.f[FC] = s17[16];
        o.f[FH] = h13[12];
        o.res = s17[15:0];
      end
      OP_ADC16, OP_SBC16: begin
        if (op == OP_ADC16) begin
          s17 = wa + wb + cy;
          h13 = wa[11:0] + wb[11:0] + cy;
        end else begin
          s17 = wa + {1'b0, ~wb} + !cy;
          h13 = wa[11:0] + {1'b0, ~wb[11:0]} + !cy;
        end
        o.f = 8'h00;
        o.f[FN] = (op == OP_SBC16);
        o.f[FC] = (op == OP_ADC16) ? s17[16] : !s17[16];
        o.f[FH] = (op == OP_ADC16) ? h13[12] : !h13[12];
        o.f[FZ] = (s17[15:0] == 16'h0000);
        o.f[FS] = s17[15];
        o.f[FV] = (op == OP_ADC16) ? (~(wa[15] ^ wb[15]) & (wa[15] ^ s17[15]))
                                   : ((wa[15] ^ wb[15]) & (wa[15] ^ s17[15]));
        o.res = s17[15:0];
      end
      OP_RRD, OP_RLD: begin
        if (op == OP_RRD) begin
          o.aux = {a[3:0], b[7:4]};
          v8 = {a[7:4], b[3:0]};
        end else begin
          o.aux = {b[3:0], a[3:0]};
          v8 = {a[7:4], b[7:4]};
        end
        o.f = zsp_flags(v8);
        o.f[FC] = cy;
        o.res = {8'h00, v8};
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_op(input logic [5:0] op, input logic [15:0] wa, input logic [15:0] wb,
                         input logic [2:0] bi, input logic [7:0] f);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= wa;
    operand_b <= wb;
    bit_index <= bi;
    flags_in  <= f;
    alu_expected_q.push_back(alu_predict(op, wa, wb, bi, f));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_random(input logic [5:0] op);
    send_op(op, 16'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (alu_expected_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_op(OP_ADD, 16'h00ff, 16'h0001, 3'd0, 8'h00);
    send_op(OP_ADD, 16'hff7f, 16'hff01, 3'd7, 8'hff);
    send_op(OP_ADC, 16'h00ff, 16'h00ff, 3'd0, 8'h01);
    send_op(OP_SUB, 16'h0000, 16'h0001, 3'd0, 8'h00);
    send_op(OP_SBC, 16'h0080, 16'h0000, 3'd0, 8'h01);
    send_op(OP_CP,  16'h0042, 16'h0042, 3'd0, 8'hff);
    send_op(OP_AND, 16'hffff, 16'hffff, 3'd0, 8'h00);
    send_op(OP_INC, 16'h0000, 16'h007f, 3'd0, 8'hff);
    send_op(OP_DEC, 16'h0000, 16'h0080, 3'd0, 8'h00);
    send_op(OP_DEC, 16'h0000, 16'h0000, 3'd0, 8'h01);
    // bit test keeps S and P/V from the incoming flags
    send_op(OP_BIT, 16'h0000, 16'h0080, 3'd7, 8'hff);
    send_op(OP_BIT, 16'h0000, 16'h007f, 3'd7, 8'h00);
    send_op(OP_RES, 16'h0000, 16'hffff, 3'd0, 8'hd7);
    send_op(OP_SET, 16'h0000, 16'h0000, 3'd7, 8'h28);
    send_op(OP_DAA, 16'h009a, 16'h0000, 3'd0, 8'h00);
    send_op(OP_DAA, 16'h0000, 16'h0000, 3'd0, 8'h13);
    send_op(OP_NEG, 16'h0080, 16'h0000, 3'd0, 8'h00);
    send_op(OP_NEG, 16'h0000, 16'h0000, 3'd0, 8'hff);
    send_op(OP_ADD16, 16'hffff, 16'h0001, 3'd0, 8'hff);
    send_op(OP_ADC16, 16'h7fff, 16'h0000, 3'd0, 8'h01);
    send_op(OP_SBC16, 16'h0000, 16'h0000, 3'd0, 8'h01);
    send_op(OP_RRD, 16'h00a5, 16'h003c, 3'd0, 8'h01);
    send_op(OP_RLD, 16'h00a5, 16'h003c, 3'd0, 8'h00);
    // undefined opcodes act as no operation
    send_op(6'd35, 16'hbeef, 16'h1234, 3'd5, 8'ha5);
    send_op(6'd63, 16'hffff, 16'hffff, 3'd7, 8'hff);
  endtask

  task automatic test_every_operation();
    for (int op = 0; op <= 34; op++) begin
      repeat (4) send_random(6'(op));
    end
  endtask

  task automatic test_random_mix(input int count);
    int op;
    for (int k = 0; k < count; k++) begin
      op = ($urandom_range(0, 19) == 0) ? $urandom_range(35, 63) : $urandom_range(0, 34);
      if ($urandom_range(0, 7) == 0)
        send_op(6'(op), {8'($urandom), ($urandom_range(0, 1) ? 8'h00 : 8'hff)},
                {8'($urandom), ($urandom_range(0, 1) ? 8'h80 : 8'h7f)},
                3'($urandom), ($urandom_range(0, 1) ? 8'h00 : 8'hff));
      else
        send_random(6'(op));
    end
  endtask

  // Result checker and receiver-side stalls
  initial begin
    alu_out_t exp_o;
    int       stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      checked_cnt++;
      if (alu_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected item res=%h aux=%h f=%h", result, aux_result, flags_out);
      end else begin
        exp_o = alu_expected_q.pop_front();
        if (result !== exp_o.res || aux_result !== exp_o.aux || flags_out !== exp_o.f) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: item %0d exp res=%h aux=%h f=%h got res=%h aux=%h f=%h",
                     checked_cnt, exp_o.res, exp_o.aux, exp_o.f,
                     result, aux_result, flags_out);
        end
      end
    end
  end

  // Watchdog on cycles without any input or output handshake
  initial begin
    idle_cnt = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= '0;
    operand_a <= '0;
    operand_b <= '0;
    bit_index <= '0;
    flags_in  <= '0;
    mismatch_cnt = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    // hold the sender until the pipeline is empty
    drain_results();
    test_every_operation();
    test_random_mix(1240);
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d items over all 35 operations and undefined codes, checked %0d results.",
             sent_cnt, checked_cnt);
    if (mismatch_cnt == 0 && alu_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, alu_expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/z80alu_pkg.sv
rtl/z80alu_stage_add.sv
rtl/z80alu_stage_flag.sv
rtl/cpu8_alu_flag_unit.sv
dv/cpu8_alu_flag_unit_test.sv
